// ===== hdl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: data widths,
// register indexes, datapath operation codes and the control/status bundles.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = DATA_W + 3;
    localparam int DIV_BITS  = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_BITS + 1);

    localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] Q_RESET = DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_COEFF = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_COEFF    = CFG_IDX_W'(3);

    typedef enum logic [3:0] {
        OP_AX,
        OP_AA,
        OP_AAP,
        OP_PH,
        OP_NUMH,
        OP_HX,
        OP_GI,
        OP_GH,
        OP_OMP
    } skf_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        logic    post_en;
        skf_op_t op;
        logic    div_start;
        logic    out_load;
    } skf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } skf_status_t;

endpackage

// ===== hdl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Serial restoring divider for the gain: (num * 2^FRAC_BITS) / den, truncated
// toward zero and saturated to the signed 32-bit range, one bit per cycle.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [skf_pkg::DATA_W-1:0]  num,
    input  logic signed [skf_pkg::DATA_W-1:0]  den,
    output logic                               done,
    output logic signed [skf_pkg::DATA_W-1:0]  quot
);
    import skf_pkg::*;

    logic                       busy_reg;
    logic                       fin_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [DATA_W-1:0]          rem_reg;
    logic [DIV_BITS-1:0]        dvd_reg;
    logic [DATA_W-1:0]          dmag_reg;
    logic                       neg_reg;
    logic signed [DATA_W-1:0]   quot_reg;

    logic [DATA_W-1:0]          num_mag;
    logic [DATA_W-1:0]          den_mag;
    logic [DATA_W+1:0]          trial;
    logic                       fits;
    logic                       over_pos;
    logic                       over_neg;
    logic [DATA_W-1:0]          q_low;
    logic signed [DATA_W-1:0]   q_sat;

    assign num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;

    assign trial = {1'b0, rem_reg, dvd_reg[DIV_BITS-1]} - {2'b00, dmag_reg};
    assign fits  = ~trial[DATA_W+1];

    assign q_low    = dvd_reg[DATA_W-1:0];
    assign over_pos = |dvd_reg[DIV_BITS-1:DATA_W-1];
    assign over_neg = (|dvd_reg[DIV_BITS-1:DATA_W])
                    | (dvd_reg[DATA_W-1] & (|dvd_reg[DATA_W-2:0]));

    always_comb begin
        if (neg_reg) begin
            if (over_neg) begin
                q_sat = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                q_sat = ~q_low + 1'b1;
            end
        end else begin
            if (over_pos) begin
                q_sat = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                q_sat = q_low;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
            dmag_reg <= den_mag;
            neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= trial[DATA_W-1:0];
            end else begin
                rem_reg <= {rem_reg[DATA_W-2:0], dvd_reg[DIV_BITS-1]};
            end
            dvd_reg <= {dvd_reg[DIV_BITS-2:0], fits};
        end
        if (fin_reg) begin
            quot_reg <= q_sat;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Datapath: configuration registers, filter state, one shared registered
// 32x32 multiplier with a saturating add stage, the gain divider and the
// output register.
// ----------------------------------------------------------------------------
module skf_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  skf_pkg::skf_cmd_t                    cmd,
    output skf_pkg::skf_status_t                 status,
    input  logic signed [skf_pkg::DATA_W-1:0]    s_measurement,
    input  logic                                 cfg_valid,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [skf_pkg::WORD_W-1:0]    m_estimate_word,
    output logic signed [skf_pkg::DATA_W-1:0]    m_estimate_full,
    output logic signed [skf_pkg::DATA_W-1:0]    m_gain_value,
    output logic                                 m_zero_divisor
);
    import skf_pkg::*;

    localparam logic signed [PROD_W-1:0] PROD_MAX =
        {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] PROD_MIN =
        {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ONE_SUM = {{(SUM_W-DATA_W){1'b0}}, ONE_FX};
    localparam logic signed [DATA_W:0] WORD_MAX =
        {{(DATA_W-WORD_W+2){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [DATA_W:0] WORD_MIN =
        {{(DATA_W-WORD_W+2){1'b1}}, {(WORD_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > PROD_MAX) begin
            return PROD_MAX[DATA_W-1:0];
        end else if (sh < PROD_MIN) begin
            return PROD_MIN[DATA_W-1:0];
        end
        return sh[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v > SUM_MAX) begin
            return SUM_MAX[DATA_W-1:0];
        end else if (v < SUM_MIN) begin
            return SUM_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    logic [DATA_W-1:0]          q_reg;
    logic [DATA_W-1:0]          r_reg;
    logic signed [DATA_W-1:0]   a_reg;
    logic signed [DATA_W-1:0]   h_reg;

    logic signed [DATA_W-1:0]   x_reg;
    logic signed [DATA_W-1:0]   p_reg;
    logic signed [DATA_W-1:0]   z_reg;
    logic signed [DATA_W-1:0]   xp_reg;
    logic signed [DATA_W-1:0]   aa_reg;
    logic signed [DATA_W-1:0]   pp_reg;
    logic signed [DATA_W-1:0]   num_reg;
    logic signed [DATA_W-1:0]   den_reg;
    logic signed [DATA_W-1:0]   innov_reg;
    logic signed [DATA_W-1:0]   om_reg;
    logic                       zero_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic                       m_valid_reg;
    logic signed [WORD_W-1:0]   word_reg;
    logic signed [DATA_W-1:0]   full_reg;
    logic signed [DATA_W-1:0]   gain_out_reg;
    logic                       zero_out_reg;

    logic                       cfg_hit;
    logic signed [DATA_W-1:0]   op_a;
    logic signed [DATA_W-1:0]   op_b;
    logic signed [DATA_W-1:0]   mul_res;
    logic signed [SUM_W-1:0]    addend;
    logic                       negate;
    logic signed [SUM_W-1:0]    mul_ext;
    logic signed [DATA_W-1:0]   post_res;
    logic                       div_done;
    logic signed [DATA_W-1:0]   div_quot;
    logic signed [DATA_W-1:0]   gain;
    logic signed [DATA_W-1:0]   x_trunc;
    logic signed [DATA_W:0]     word_wide;
    logic signed [WORD_W-1:0]   word_sat;

    always_comb begin
        unique case (cfg_index)
            REG_PROCESS_NOISE:    cfg_hit = 1'b1;
            REG_MEASURE_NOISE:    cfg_hit = 1'b1;
            REG_TRANSITION_COEFF: cfg_hit = 1'b1;
            REG_OBSERVE_COEFF:    cfg_hit = 1'b1;
            default:              cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= Q_RESET;
            r_reg <= ONE_FX;
            a_reg <= ONE_FX;
            h_reg <= ONE_FX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROCESS_NOISE:    q_reg <= cfg_data;
                REG_MEASURE_NOISE:    r_reg <= cfg_data;
                REG_TRANSITION_COEFF: a_reg <= cfg_data;
                REG_OBSERVE_COEFF:    h_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cmd.op)
            OP_AX:   begin op_a = a_reg;   op_b = x_reg;     end
            OP_AA:   begin op_a = a_reg;   op_b = a_reg;     end
            OP_AAP:  begin op_a = aa_reg;  op_b = p_reg;     end
            OP_PH:   begin op_a = pp_reg;  op_b = h_reg;     end
            OP_NUMH: begin op_a = num_reg; op_b = h_reg;     end
            OP_HX:   begin op_a = h_reg;   op_b = xp_reg;    end
            OP_GI:   begin op_a = gain;    op_b = innov_reg; end
            OP_GH:   begin op_a = gain;    op_b = h_reg;     end
            OP_OMP:  begin op_a = om_reg;  op_b = pp_reg;    end
            default: begin op_a = '0;      op_b = '0;        end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign mul_res = sat_prod(prod_reg);
    assign mul_ext = {{(SUM_W-DATA_W){mul_res[DATA_W-1]}}, mul_res};

    always_comb begin
        negate = 1'b0;
        unique case (cmd.op)
            OP_AAP:  addend = {{(SUM_W-DATA_W){1'b0}}, q_reg};
            OP_NUMH: addend = {{(SUM_W-DATA_W){1'b0}}, r_reg};
            OP_HX: begin
                addend = {{(SUM_W-DATA_W){z_reg[DATA_W-1]}}, z_reg};
                negate = 1'b1;
            end
            OP_GI:   addend = {{(SUM_W-DATA_W){xp_reg[DATA_W-1]}}, xp_reg};
            OP_GH: begin
                addend = ONE_SUM;
                negate = 1'b1;
            end
            default: addend = '0;
        endcase
    end

    assign post_res = sat_sum(negate ? (addend - mul_ext) : (addend + mul_ext));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            z_reg <= s_measurement;
        end
        if (cmd.div_start) begin
            zero_reg <= (den_reg == '0);
        end
        if (cmd.post_en) begin
            unique case (cmd.op)
                OP_AX:   xp_reg    <= post_res;
                OP_AA:   aa_reg    <= post_res;
                OP_AAP:  pp_reg    <= post_res;
                OP_PH:   num_reg   <= post_res;
                OP_NUMH: den_reg   <= post_res;
                OP_HX:   innov_reg <= post_res;
                OP_GH:   om_reg    <= post_res;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            p_reg <= '0;
        end else if (cfg_valid && cfg_hit) begin
            x_reg <= '0;
            p_reg <= '0;
        end else if (cmd.post_en && cmd.op == OP_GI) begin
            x_reg <= post_res;
        end else if (cmd.post_en && cmd.op == OP_OMP) begin
            p_reg <= post_res;
        end
    end

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign gain = zero_reg ? '0 : div_quot;

    assign x_trunc   = x_reg >>> FRAC_BITS;
    assign word_wide = {x_trunc[DATA_W-1], x_trunc}
                     + {{DATA_W{1'b0}}, (x_reg[DATA_W-1] & (|x_reg[FRAC_BITS-1:0]))};

    always_comb begin
        if (word_wide > WORD_MAX) begin
            word_sat = WORD_MAX[WORD_W-1:0];
        end else if (word_wide < WORD_MIN) begin
            word_sat = WORD_MIN[WORD_W-1:0];
        end else begin
            word_sat = word_wide[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            word_reg     <= word_sat;
            full_reg     <= x_reg;
            gain_out_reg <= gain;
            zero_out_reg <= zero_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid         = m_valid_reg;
    assign m_estimate_word = word_reg;
    assign m_estimate_full = full_reg;
    assign m_gain_value    = gain_out_reg;
    assign m_zero_divisor  = zero_out_reg;

endmodule

// ===== hdl/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skf_ctrl
// Controller: steps one measurement through the multiply passes, starts the
// gain division and runs the innovation multiply while the divider works.
// ----------------------------------------------------------------------------
module skf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output skf_pkg::skf_cmd_t     cmd,
    input  skf_pkg::skf_status_t  status
);
    import skf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_DIV,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    state_t  state_reg;
    skf_op_t op_reg;
    skf_op_t op_succ;

    always_comb begin
        unique case (op_reg)
            OP_AX:   op_succ = OP_AA;
            OP_AA:   op_succ = OP_AAP;
            OP_AAP:  op_succ = OP_PH;
            OP_PH:   op_succ = OP_NUMH;
            OP_GI:   op_succ = OP_GH;
            OP_GH:   op_succ = OP_OMP;
            default: op_succ = OP_AX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_AX;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_MUL;
                        op_reg    <= OP_AX;
                    end
                end
                S_MUL: begin
                    state_reg <= S_POST;
                end
                S_POST: begin
                    if (op_reg == OP_NUMH) begin
                        state_reg <= S_DIV;
                    end else if (op_reg == OP_HX) begin
                        state_reg <= S_DIV_WAIT;
                    end else if (op_reg == OP_OMP) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_MUL;
                        op_reg    <= op_succ;
                    end
                end
                S_DIV: begin
                    state_reg <= S_MUL;
                    op_reg    <= OP_HX;
                end
                S_DIV_WAIT: begin
                    if (status.div_done) begin
                        state_reg <= S_MUL;
                        op_reg    <= OP_GI;
                    end
                end
                S_DONE: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign cmd.load      = s_valid && (state_reg == S_IDLE);
    assign cmd.mul_en    = (state_reg == S_MUL);
    assign cmd.post_en   = (state_reg == S_POST);
    assign cmd.op        = op_reg;
    assign cmd.div_start = (state_reg == S_DIV);
    assign cmd.out_load  = (state_reg == S_DONE) && status.out_free;

endmodule

// ===== hdl/scalar_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional Kalman filter in signed Q16.16 fixed point: one estimate,
// gain and zero-divisor flag per measurement transaction.
//
//   Channel   Handshake              Payload
//   input     s_valid / s_ready      s_measurement
//   result    m_valid / m_ready      m_estimate_word, m_estimate_full,
//                                    m_gain_value, m_zero_divisor
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A result becomes valid after the last pass and the output load; s_ready
// rises in the same cycle, so the next measurement can be accepted then. The
// serial gain divider takes most of the time for a measurement: 48
// iterations, a saturation step and a done step, with the innovation multiply
// run alongside. The eight other passes through the single shared 32x32
// multiplier each take a multiply state and an add state, and the divider
// start and the output load take one state each. One measurement is processed
// at a time. A finished result waits in the output register while the next
// measurement is taken; that next result then holds off s_ready until the
// output is free. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]    s_measurement,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [skf_pkg::WORD_W-1:0]    m_estimate_word,
    output logic signed [skf_pkg::DATA_W-1:0]    m_estimate_full,
    output logic signed [skf_pkg::DATA_W-1:0]    m_gain_value,
    output logic                                 m_zero_divisor,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]           cfg_data
);
    import skf_pkg::*;

    skf_cmd_t    cmd;
    skf_status_t status;

    assign cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    skf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_measurement   (s_measurement),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_estimate_word (m_estimate_word),
        .m_estimate_full (m_estimate_full),
        .m_gain_value    (m_gain_value),
        .m_zero_divisor  (m_zero_divisor)
    );

endmodule
